// ===== rtl/ldm_pkg.sv =====
// Shared types, widths and register codes for the lens distortion map unit.
`timescale 1ns / 1ps

package ldm_pkg;

    // Field and register widths
    localparam int COORD_W   = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    // Fractional bits of the normalized and coefficient formats
    localparam int FRAC = 28;

    // Internal widths, each sized to the largest magnitude the value can reach
    localparam int SQ_W    = 36;  // x*x, y*y, x*y
    localparam int R2_W    = 37;  // r^2
    localparam int SX_W    = 38;  // r^2 + 2x^2
    localparam int R4_W    = 44;
    localparam int R6_W    = 51;
    localparam int K1R2_W  = 40;
    localparam int K2R4_W  = 47;
    localparam int K3R6_W  = 54;
    localparam int PART_W  = 48;  // 1 + k1 r^2 + k2 r^4
    localparam int RAD_W   = 55;
    localparam int PXY_W   = 39;  // p * xy
    localparam int PSX_W   = 41;  // p * (r^2 + 2x^2)
    localparam int TX_W    = 42;  // tangential sum
    localparam int XRAD_W  = 58;
    localparam int XD_W    = 59;
    localparam int FOC_W   = 33;  // unsigned focal length as a signed operand
    localparam int FXD_W   = 63;
    localparam int SUM_W   = 64;

    // Register stages from input register to output register
    localparam int STAGES = 17;

    localparam logic signed [PART_W-1:0] ONE_Q = PART_W'(1) << FRAC;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X    = 3'd0,
        REG_FOCAL_Y    = 3'd1,
        REG_CENTER_X   = 3'd2,
        REG_CENTER_Y   = 3'd3,
        REG_RADIAL_K1  = 3'd4,
        REG_RADIAL_K2  = 3'd5,
        REG_RADIAL_K3  = 3'd6,
        REG_TANGENTIAL = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] norm_x;
        logic signed [COORD_W-1:0] norm_y;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pix_x;
        logic signed [COORD_W-1:0] pix_y;
        logic                      saturated;
    } pixel_t;

endpackage

// ===== rtl/ldm_mulq.sv =====
// Two-stage signed fixed-point multiplier: split partial products, then sum and floor shift.
`timescale 1ns / 1ps

module ldm_mulq #(
    parameter int WA = ldm_pkg::COORD_W,
    parameter int WB = ldm_pkg::COORD_W,
    parameter int WP = ldm_pkg::SQ_W
) (
    input  logic                 clk,
    input  logic                 en_mul,
    input  logic                 en_sum,
    input  logic signed [WA-1:0] a,
    input  logic signed [WB-1:0] b,
    output logic signed [WP-1:0] p
);

    localparam int LO    = WB / 2;
    localparam int HI    = WB - LO;
    localparam int WFULL = WA + WB;
    localparam int WPL   = WA + LO + 1;
    localparam int WPH   = WA + HI;
    localparam int FRAC  = ldm_pkg::FRAC;

    logic signed [WPL-1:0]   pp_lo_reg;
    logic signed [WPL-1:0]   pp_lo_next;
    logic signed [WPH-1:0]   pp_hi_reg;
    logic signed [WPH-1:0]   pp_hi_next;
    logic signed [WFULL-1:0] full;
    logic signed [WP-1:0]    p_reg;
    logic signed [WP-1:0]    p_next;

    // Low half of b is unsigned, high half carries the sign
    always_comb
    begin
        pp_lo_next = a * $signed({1'b0, b[LO-1:0]});
        pp_hi_next = a * $signed(b[WB-1:LO]);
    end

    // Exact product; dropping the low bits floors toward minus infinity
    always_comb
    begin
        full   = $signed({pp_hi_reg, {LO{1'b0}}}) + WFULL'(pp_lo_reg);
        p_next = full[FRAC +: WP];
    end

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
        end
        if (en_sum)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/lens_distortion_map_unit.sv =====
// Top level of the lens distortion map unit: Brown-Conrady distortion and pixel projection.
`timescale 1ns / 1ps

// Maps an undistorted normalized point (signed Q4.28) to its distorted pixel
// position (signed Q16.16) with radial terms k1..k3, tangential p1/p2,
// focal lengths and principal point.
// Point channel: point_valid / point_stall / point. Pixel channel:
// pixel_valid / pixel_stall / pixel. An item moves at a rising edge with
// valid high and stall low.
// Configuration: write cfg_data to the register cfg_index selects while
// cfg_we is high; write only while no item is in flight.
// Pipeline: a point passes through 17 register stages (input, six two-stage
// multiply groups, adders and the saturating output register).
// Throughput: one point per cycle while the receiver does not stall, set by
// the fully pipelined multipliers.
// A stalled receiver holds the output register; upstream stages keep filling
// empty slots, and point_stall rises only once the stage behind the input
// register is occupied and cannot advance.
// Reset clears all stage valid bits and returns the registers to focal
// lengths of 1.0 with every other coefficient zero.
module lens_distortion_map_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                point_valid,
    output logic                                point_stall,
    input  ldm_pkg::point_t                     point,
    output logic                                pixel_valid,
    input  logic                                pixel_stall,
    output ldm_pkg::pixel_t                     pixel,
    input  logic                                cfg_we,
    input  logic [ldm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ldm_pkg::CFG_W-1:0]           cfg_data
);

    localparam int CW      = ldm_pkg::COORD_W;
    localparam int NST     = ldm_pkg::STAGES;
    localparam int SX_W    = ldm_pkg::SX_W;
    localparam int R2_W    = ldm_pkg::R2_W;
    localparam int SQ_W    = ldm_pkg::SQ_W;
    localparam int TX_W    = ldm_pkg::TX_W;
    localparam int PART_W  = ldm_pkg::PART_W;
    localparam int RAD_W   = ldm_pkg::RAD_W;
    localparam int XD_W    = ldm_pkg::XD_W;
    localparam int SUM_W   = ldm_pkg::SUM_W;
    localparam int K1R2_W  = ldm_pkg::K1R2_W;
    localparam int PXY_W   = ldm_pkg::PXY_W;
    localparam int PSX_W   = ldm_pkg::PSX_W;

    // Configuration registers
    logic [CW-1:0]                    focal_x_reg;
    logic [CW-1:0]                    focal_y_reg;
    logic [CW-1:0]                    center_x_reg;
    logic [CW-1:0]                    center_y_reg;
    logic signed [CW-1:0]             radial_k1_reg;
    logic signed [CW-1:0]             radial_k2_reg;
    logic signed [CW-1:0]             radial_k3_reg;
    logic [ldm_pkg::CFG_W-1:0]        tangential_reg;

    logic signed [CW-1:0]             p1;
    logic signed [CW-1:0]             p2;
    logic signed [ldm_pkg::FOC_W-1:0] fx;
    logic signed [ldm_pkg::FOC_W-1:0] fy;

    // Pipeline control
    logic [NST-1:0]                   vld_reg;
    logic [NST-1:0]                   ld;

    // Stage payload
    logic signed [CW-1:0]             x_pipe_reg [0:10];
    logic signed [CW-1:0]             y_pipe_reg [0:10];
    logic signed [R2_W-1:0]           r2_pipe_reg [3:5];
    logic signed [SQ_W-1:0]           xy_reg;
    logic signed [SX_W-1:0]           sx_reg;
    logic signed [SX_W-1:0]           sy_reg;
    logic signed [K1R2_W-1:0]         k1r2_pipe_reg [6:7];
    logic signed [TX_W-1:0]           tx_pipe_reg [6:12];
    logic signed [TX_W-1:0]           ty_pipe_reg [6:12];
    logic signed [PART_W-1:0]         part_pipe_reg [8:9];
    logic signed [RAD_W-1:0]          rad_reg;
    logic signed [XD_W-1:0]           xd_reg;
    logic signed [XD_W-1:0]           yd_reg;
    ldm_pkg::pixel_t                  pix_reg;

    logic signed [R2_W-1:0]           r2_next;
    logic signed [SX_W-1:0]           sx_next;
    logic signed [SX_W-1:0]           sy_next;
    logic signed [TX_W-1:0]           tx_next;
    logic signed [TX_W-1:0]           ty_next;
    logic signed [PART_W-1:0]         part_next;
    logic signed [RAD_W-1:0]          rad_next;
    logic signed [XD_W-1:0]           xd_next;
    logic signed [XD_W-1:0]           yd_next;
    ldm_pkg::pixel_t                  pix_next;

    // Multiplier results
    logic signed [SQ_W-1:0]               xx;
    logic signed [SQ_W-1:0]               yy;
    logic signed [SQ_W-1:0]               xy;
    logic signed [ldm_pkg::R4_W-1:0]      r4;
    logic signed [K1R2_W-1:0]             k1r2;
    logic signed [PXY_W-1:0]              p1xy;
    logic signed [PXY_W-1:0]              p2xy;
    logic signed [PSX_W-1:0]              p2sx;
    logic signed [PSX_W-1:0]              p1sy;
    logic signed [ldm_pkg::R6_W-1:0]      r6;
    logic signed [ldm_pkg::K2R4_W-1:0]    k2r4;
    logic signed [ldm_pkg::K3R6_W-1:0]    k3r6;
    logic signed [ldm_pkg::XRAD_W-1:0]    xrad;
    logic signed [ldm_pkg::XRAD_W-1:0]    yrad;
    logic signed [ldm_pkg::FXD_W-1:0]     fxd;
    logic signed [ldm_pkg::FXD_W-1:0]     fyd;

    logic signed [SUM_W-1:0]          sum_x;
    logic signed [SUM_W-1:0]          sum_y;
    logic                             ovf_x;
    logic                             ovf_y;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg    <= CW'(65536);
            focal_y_reg    <= CW'(65536);
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            radial_k1_reg  <= '0;
            radial_k2_reg  <= '0;
            radial_k3_reg  <= '0;
            tangential_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ldm_pkg::REG_FOCAL_X:    focal_x_reg    <= cfg_data[CW-1:0];
                ldm_pkg::REG_FOCAL_Y:    focal_y_reg    <= cfg_data[CW-1:0];
                ldm_pkg::REG_CENTER_X:   center_x_reg   <= cfg_data[CW-1:0];
                ldm_pkg::REG_CENTER_Y:   center_y_reg   <= cfg_data[CW-1:0];
                ldm_pkg::REG_RADIAL_K1:  radial_k1_reg  <= cfg_data[CW-1:0];
                ldm_pkg::REG_RADIAL_K2:  radial_k2_reg  <= cfg_data[CW-1:0];
                ldm_pkg::REG_RADIAL_K3:  radial_k3_reg  <= cfg_data[CW-1:0];
                ldm_pkg::REG_TANGENTIAL: tangential_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign p1 = $signed(tangential_reg[CW-1:0]);
    assign p2 = $signed(tangential_reg[2*CW-1:CW]);
    assign fx = $signed({1'b0, focal_x_reg});
    assign fy = $signed({1'b0, focal_y_reg});

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when empty or when the next one moves
    // ------------------------------------------------------------------
    always_comb
    begin
        ld[NST-1] = !vld_reg[NST-1] || !pixel_stall;
        for (int k = NST - 2; k >= 0; k--)
        begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end

    assign point_stall = !ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                vld_reg[0] <= point_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (ld[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Carried operands
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            x_pipe_reg[0] <= point.norm_x;
            y_pipe_reg[0] <= point.norm_y;
        end
        for (int k = 1; k <= 10; k++)
        begin
            if (ld[k])
            begin
                x_pipe_reg[k] <= x_pipe_reg[k-1];
                y_pipe_reg[k] <= y_pipe_reg[k-1];
            end
        end
        for (int k = 4; k <= 5; k++)
        begin
            if (ld[k])
            begin
                r2_pipe_reg[k] <= r2_pipe_reg[k-1];
            end
        end
        if (ld[7])
        begin
            k1r2_pipe_reg[7] <= k1r2_pipe_reg[6];
        end
        for (int k = 7; k <= 12; k++)
        begin
            if (ld[k])
            begin
                tx_pipe_reg[k] <= tx_pipe_reg[k-1];
                ty_pipe_reg[k] <= ty_pipe_reg[k-1];
            end
        end
        if (ld[9])
        begin
            part_pipe_reg[9] <= part_pipe_reg[8];
        end
    end

    // ------------------------------------------------------------------
    // Stages 1-2: squares and cross product
    // ------------------------------------------------------------------
    ldm_mulq #(.WA(CW), .WB(CW), .WP(SQ_W)) u_mul_xx (
        .clk(clk), .en_mul(ld[1]), .en_sum(ld[2]),
        .a(x_pipe_reg[0]), .b(x_pipe_reg[0]), .p(xx)
    );

    ldm_mulq #(.WA(CW), .WB(CW), .WP(SQ_W)) u_mul_yy (
        .clk(clk), .en_mul(ld[1]), .en_sum(ld[2]),
        .a(y_pipe_reg[0]), .b(y_pipe_reg[0]), .p(yy)
    );

    ldm_mulq #(.WA(CW), .WB(CW), .WP(SQ_W)) u_mul_xy (
        .clk(clk), .en_mul(ld[1]), .en_sum(ld[2]),
        .a(x_pipe_reg[0]), .b(y_pipe_reg[0]), .p(xy)
    );

    // Stage 3: r^2 and the tangential radius terms
    always_comb
    begin
        r2_next = R2_W'(xx) + R2_W'(yy);
        sx_next = SX_W'(xx) + SX_W'(yy) + (SX_W'(xx) <<< 1);
        sy_next = SX_W'(xx) + SX_W'(yy) + (SX_W'(yy) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            r2_pipe_reg[3] <= r2_next;
            sx_reg         <= sx_next;
            sy_reg         <= sy_next;
            xy_reg         <= xy;
        end
    end

    // ------------------------------------------------------------------
    // Stages 4-5: r^4, k1 r^2 and tangential products
    // ------------------------------------------------------------------
    ldm_mulq #(.WA(R2_W), .WB(R2_W), .WP(ldm_pkg::R4_W)) u_mul_r4 (
        .clk(clk), .en_mul(ld[4]), .en_sum(ld[5]),
        .a(r2_pipe_reg[3]), .b(r2_pipe_reg[3]), .p(r4)
    );

    ldm_mulq #(.WA(CW), .WB(R2_W), .WP(K1R2_W)) u_mul_k1r2 (
        .clk(clk), .en_mul(ld[4]), .en_sum(ld[5]),
        .a(radial_k1_reg), .b(r2_pipe_reg[3]), .p(k1r2)
    );

    ldm_mulq #(.WA(CW), .WB(SQ_W), .WP(PXY_W)) u_mul_p1xy (
        .clk(clk), .en_mul(ld[4]), .en_sum(ld[5]),
        .a(p1), .b(xy_reg), .p(p1xy)
    );

    ldm_mulq #(.WA(CW), .WB(SQ_W), .WP(PXY_W)) u_mul_p2xy (
        .clk(clk), .en_mul(ld[4]), .en_sum(ld[5]),
        .a(p2), .b(xy_reg), .p(p2xy)
    );

    ldm_mulq #(.WA(CW), .WB(SX_W), .WP(PSX_W)) u_mul_p2sx (
        .clk(clk), .en_mul(ld[4]), .en_sum(ld[5]),
        .a(p2), .b(sx_reg), .p(p2sx)
    );

    ldm_mulq #(.WA(CW), .WB(SX_W), .WP(PSX_W)) u_mul_p1sy (
        .clk(clk), .en_mul(ld[4]), .en_sum(ld[5]),
        .a(p1), .b(sy_reg), .p(p1sy)
    );

    // Stage 6: tangential sums
    always_comb
    begin
        tx_next = (TX_W'(p1xy) <<< 1) + TX_W'(p2sx);
        ty_next = (TX_W'(p2xy) <<< 1) + TX_W'(p1sy);
    end

    always_ff @(posedge clk)
    begin
        if (ld[6])
        begin
            tx_pipe_reg[6]   <= tx_next;
            ty_pipe_reg[6]   <= ty_next;
            k1r2_pipe_reg[6] <= k1r2;
        end
    end

    // ------------------------------------------------------------------
    // Stages 6-7: r^6 and k2 r^4
    // ------------------------------------------------------------------
    ldm_mulq #(.WA(R2_W), .WB(ldm_pkg::R4_W), .WP(ldm_pkg::R6_W)) u_mul_r6 (
        .clk(clk), .en_mul(ld[6]), .en_sum(ld[7]),
        .a(r2_pipe_reg[5]), .b(r4), .p(r6)
    );

    ldm_mulq #(.WA(CW), .WB(ldm_pkg::R4_W), .WP(ldm_pkg::K2R4_W)) u_mul_k2r4 (
        .clk(clk), .en_mul(ld[6]), .en_sum(ld[7]),
        .a(radial_k2_reg), .b(r4), .p(k2r4)
    );

    // Stage 8: partial radial factor
    always_comb
    begin
        part_next = ldm_pkg::ONE_Q + PART_W'(k1r2_pipe_reg[7]) + PART_W'(k2r4);
    end

    always_ff @(posedge clk)
    begin
        if (ld[8])
        begin
            part_pipe_reg[8] <= part_next;
        end
    end

    // Stages 8-9: k3 r^6
    ldm_mulq #(.WA(CW), .WB(ldm_pkg::R6_W), .WP(ldm_pkg::K3R6_W)) u_mul_k3r6 (
        .clk(clk), .en_mul(ld[8]), .en_sum(ld[9]),
        .a(radial_k3_reg), .b(r6), .p(k3r6)
    );

    // Stage 10: full radial factor
    always_comb
    begin
        rad_next = RAD_W'(part_pipe_reg[9]) + RAD_W'(k3r6);
    end

    always_ff @(posedge clk)
    begin
        if (ld[10])
        begin
            rad_reg <= rad_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 11-12: scale by the radial factor
    // ------------------------------------------------------------------
    ldm_mulq #(.WA(CW), .WB(RAD_W), .WP(ldm_pkg::XRAD_W)) u_mul_xrad (
        .clk(clk), .en_mul(ld[11]), .en_sum(ld[12]),
        .a(x_pipe_reg[10]), .b(rad_reg), .p(xrad)
    );

    ldm_mulq #(.WA(CW), .WB(RAD_W), .WP(ldm_pkg::XRAD_W)) u_mul_yrad (
        .clk(clk), .en_mul(ld[11]), .en_sum(ld[12]),
        .a(y_pipe_reg[10]), .b(rad_reg), .p(yrad)
    );

    // Stage 13: distorted normalized point
    always_comb
    begin
        xd_next = XD_W'(xrad) + XD_W'(tx_pipe_reg[12]);
        yd_next = XD_W'(yrad) + XD_W'(ty_pipe_reg[12]);
    end

    always_ff @(posedge clk)
    begin
        if (ld[13])
        begin
            xd_reg <= xd_next;
            yd_reg <= yd_next;
        end
    end

    // Stages 14-15: focal length
    ldm_mulq #(.WA(ldm_pkg::FOC_W), .WB(XD_W), .WP(ldm_pkg::FXD_W)) u_mul_fx (
        .clk(clk), .en_mul(ld[14]), .en_sum(ld[15]),
        .a(fx), .b(xd_reg), .p(fxd)
    );

    ldm_mulq #(.WA(ldm_pkg::FOC_W), .WB(XD_W), .WP(ldm_pkg::FXD_W)) u_mul_fy (
        .clk(clk), .en_mul(ld[14]), .en_sum(ld[15]),
        .a(fy), .b(yd_reg), .p(fyd)
    );

    // ------------------------------------------------------------------
    // Stage 16: principal point and saturation to Q16.16
    // ------------------------------------------------------------------
    always_comb
    begin
        sum_x = SUM_W'(fxd) + $signed({{(SUM_W - CW){1'b0}}, center_x_reg});
        sum_y = SUM_W'(fyd) + $signed({{(SUM_W - CW){1'b0}}, center_y_reg});

        // Out of range when the bits above the sign are not all equal to it
        ovf_x = (sum_x[SUM_W-1:CW-1] != {(SUM_W - CW + 1){sum_x[SUM_W-1]}});
        ovf_y = (sum_y[SUM_W-1:CW-1] != {(SUM_W - CW + 1){sum_y[SUM_W-1]}});

        if (ovf_x)
        begin
            pix_next.pix_x = {sum_x[SUM_W-1], {(CW - 1){!sum_x[SUM_W-1]}}};
        end
        else
        begin
            pix_next.pix_x = sum_x[CW-1:0];
        end

        if (ovf_y)
        begin
            pix_next.pix_y = {sum_y[SUM_W-1], {(CW - 1){!sum_y[SUM_W-1]}}};
        end
        else
        begin
            pix_next.pix_y = sum_y[CW-1:0];
        end

        pix_next.saturated = ovf_x || ovf_y;
    end

    always_ff @(posedge clk)
    begin
        if (ld[NST-1])
        begin
            pix_reg <= pix_next;
        end
    end

    assign pixel_valid = vld_reg[NST-1];
    assign pixel       = pix_reg;

endmodule
